// ===== src/ipx_pkg.sv =====
// ----------------------------------------------------------------------------
// ipx_pkg: shared types and constants for the palette expander
// Item structs, queue entry, register map and reset values.
// ----------------------------------------------------------------------------
package ipx_pkg;

    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int Q_DEPTH             = 2;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_DEPTH_CODE   = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [1:0] DEPTH_CODE_RST   = 2'd2;
    localparam logic [9:0] LINE_WIDTH_RST   = 10'd160;
    localparam logic [9:0] FRAME_HEIGHT_RST = 10'd480;

    typedef struct packed {
        logic        op;
        logic [15:0] payload;
        logic [3:0]  entry_select;
    } t_in_item;

    typedef struct packed {
        logic [31:0] argb;
        logic [9:0]  column;
        logic [9:0]  row;
        logic        last_of_byte;
        logic        frame_end;
    } t_out_item;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_PAL   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] data;
        logic [3:0]  sel;
    } t_q_entry;

    typedef struct packed {
        logic [1:0] depth_code;
        logic [9:0] line_width;
        logic [9:0] frame_height;
    } t_cfg;

endpackage

// ===== src/indexed_pixel_palette_expander.sv =====
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expander: indexed pixel to ARGB8888 expander
// Path: an input transfer goes through the queue, the palette read stage
// and the output register. Throughput: one pixel per cycle unless the output
// stalls, set by the back end walking one palette read per pixel.
// Reset clears counters, queue and palette valid bits at once.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_expander #(
    parameter int PALETTE_ENTRIES = ipx_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ipx_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ipx_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipx_pkg::CFG_AW-1:0] paddr,
    input  logic [ipx_pkg::CFG_DW-1:0] pwdata,
    output logic [ipx_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import ipx_pkg::*;

    t_cfg       r_cfg;
    logic       q_valid;
    t_q_entry   q_head;
    logic       q_pop;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_code   <= DEPTH_CODE_RST;
            r_cfg.line_width   <= LINE_WIDTH_RST;
            r_cfg.frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEPTH_CODE:   r_cfg.depth_code   <= pwdata[1:0];
                REG_LINE_WIDTH:   r_cfg.line_width   <= pwdata[9:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[9:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEPTH_CODE:   prdata = {30'd0, r_cfg.depth_code};
            REG_LINE_WIDTH:   prdata = {22'd0, r_cfg.line_width};
            REG_FRAME_HEIGHT: prdata = {22'd0, r_cfg.frame_height};
            default:          prdata = '0;
        endcase
    end

    ipx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .o_q_valid (q_valid),
        .o_q_head  (q_head),
        .i_q_pop   (q_pop)
    );

    ipx_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.last_of_byte)
        else $error("frame_end without last_of_byte");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.argb[31:24] == 8'hFF))
        else $error("alpha byte not opaque");

    a_stall_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("queue filled without an input transfer");
`endif

endmodule

// ===== src/ipx_ram.sv =====
// ----------------------------------------------------------------------------
// ipx_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ipx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ipx_front.sv =====
// ----------------------------------------------------------------------------
// ipx_front: input classification and transfer queue
// Sorts each input transfer into a pixel byte or a palette write and holds
// it in a short queue until the back end takes it.
// ----------------------------------------------------------------------------
module ipx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ipx_pkg::t_in_item i_data,
    output logic              o_q_valid,
    output ipx_pkg::t_q_entry o_q_head,
    input  logic              i_q_pop
);
    import ipx_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_q_entry       r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_cnt;
    t_q_entry       entry;
    logic           push;

    always_comb begin
        entry.kind = i_data.op ? KIND_PAL : KIND_PIXEL;
        entry.data = i_data.op ? i_data.payload : {8'd0, i_data.payload[7:0]};
        entry.sel  = i_data.entry_select;
    end

    assign o_stall   = (r_cnt == QCW'(Q_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= entry;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= (r_rptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/ipx_back.sv =====
// ----------------------------------------------------------------------------
// ipx_back: pixel unpacker, palette lookup and color expansion
// Applies palette writes, walks each byte one pixel per cycle unless stalled,
// tracks the column and row counters and drives the output register.
// ----------------------------------------------------------------------------
module ipx_back #(
    parameter int PALETTE_ENTRIES = ipx_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipx_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  ipx_pkg::t_q_entry  i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ipx_pkg::t_out_item o_out_data
);
    import ipx_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    function automatic logic [31:0] expand565(input logic [15:0] c);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r8 = {c[15:11], c[15:13]};
        g8 = {c[10:5], c[10:9]};
        b8 = {c[4:0], c[4:2]};
        return {8'hFF, r8, g8, b8};
    endfunction

    logic [PALETTE_ENTRIES-1:0] r_pal_vld;
    logic [9:0]  r_col;
    logic [9:0]  r_row;
    logic [2:0]  r_k;
    logic [9:0]  n_col;
    logic [9:0]  n_row;
    logic [2:0]  n_k;

    logic        r_s1_vld;
    logic        r_s1_pvld;
    logic [9:0]  r_s1_col;
    logic [9:0]  r_s1_row;
    logic        r_s1_last;
    logic        r_s1_fend;
    logic        r_out_vld;
    t_out_item   r_out;

    logic        en;
    logic        pal_we;
    logic        issue;
    logic [1:0]  dsel;
    logic [3:0]  mask;
    logic [2:0]  k_last;
    logic [2:0]  shamt;
    logic [3:0]  idx;
    logic [10:0] width;
    logic [10:0] height;
    logic        line_last;
    logic        frame_last;
    logic        byte_last;
    logic [15:0] rdata;
    logic [15:0] color;

    assign en     = !r_out_vld || !i_out_stall;
    assign pal_we = i_q_valid && (i_q_head.kind == KIND_PAL);
    assign issue  = i_q_valid && (i_q_head.kind == KIND_PIXEL);

    always_comb begin
        dsel = (i_cfg.depth_code >= 2'd2) ? 2'd2 : i_cfg.depth_code;
        case (dsel)
            2'd0:    begin mask = 4'h1; k_last = 3'd7; end
            2'd1:    begin mask = 4'h3; k_last = 3'd3; end
            default: begin mask = 4'hF; k_last = 3'd1; end
        endcase
        shamt  = r_k << dsel;
        idx    = 4'(i_q_head.data[7:0] >> shamt) & mask;
        width  = (i_cfg.line_width == '0) ? 11'd1024 : {1'b0, i_cfg.line_width};
        height = (i_cfg.frame_height == '0) ? 11'd1024 : {1'b0, i_cfg.frame_height};
        line_last  = ({1'b0, r_col} + 11'd1) >= width;
        frame_last = line_last && (({1'b0, r_row} + 11'd1) >= height);
        byte_last  = frame_last || (r_k == k_last);

        n_col = r_col;
        n_row = r_row;
        n_k   = r_k;
        if (issue && en) begin
            n_k = byte_last ? 3'd0 : r_k + 3'd1;
            if (frame_last) begin
                n_col = '0;
                n_row = '0;
            end else if (line_last) begin
                n_col = '0;
                n_row = r_row + 10'd1;
            end else begin
                n_col = r_col + 10'd1;
            end
        end
    end

    assign o_q_pop = pal_we || (issue && en && byte_last);

    ipx_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (PAL_AW'(i_q_head.sel)),
        .i_wdata (i_q_head.data),
        .i_re    (issue && en),
        .i_raddr (PAL_AW'(idx)),
        .o_rdata (rdata)
    );

    assign color = r_s1_pvld ? rdata : 16'd0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_last <= byte_last;
            r_s1_fend <= frame_last;
            r_out.argb         <= expand565(color);
            r_out.column       <= r_s1_col;
            r_out.row          <= r_s1_row;
            r_out.last_of_byte <= r_s1_last;
            r_out.frame_end    <= r_s1_fend;
        end
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_k       <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_pvld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (pal_we) begin
                r_pal_vld[PAL_AW'(i_q_head.sel)] <= 1'b1;
            end
            r_col <= n_col;
            r_row <= n_row;
            r_k   <= n_k;
            if (en) begin
                r_s1_vld  <= issue;
                r_s1_pvld <= r_pal_vld[PAL_AW'(idx)];
                r_out_vld <= r_s1_vld;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
